FILE: src/scf_pkg.sv
// scf_pkg: shared types, character codes and helper functions for the
// serial command framer; no dependencies
`default_nettype none

package scf_pkg;

  // depth of the queue between the classifier and the framing back end
  localparam int QUEUE_DEPTH = 2;

  // number of frame positions seen by the decoder, and parameter bytes carried
  localparam int VIEW_SLOTS = 7;
  localparam int ARG_BYTES  = 5;

  // character codes
  localparam logic [7:0] CHAR_END   = 8'h23;  // '#'
  localparam logic [7:0] CHAR_SKIP  = 8'h3A;  // ':'
  localparam logic [7:0] CHAR_C     = 8'h43;  // 'C'
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CHAR_A     = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_Z     = 8'h5A;  // 'Z'

  // what the back end has to do with a queued word
  typedef enum logic {
    WORD_APPEND,
    WORD_END
  } word_kind_t;

  typedef struct packed {
    word_kind_t kind;
    logic [7:0] data;
  } queue_word_t;

  // a word offered to, or held at the head of, the queue
  typedef struct packed {
    logic        valid;
    queue_word_t word;
  } queue_port_t;

  // membership of the allowed character set
  function automatic logic char_allowed(input logic [7:0] b);
    logic ok;
    unique case (b) inside
      ":", "#", "D", "C", "F", "G", "S", "+", "-", "Q", "P", "Y", "Z",
      "H", "I", "N", "T", "V", "O", "M", "B", "X", "A", "E", "d",
      [8'h30:8'h39]: ok = 1'b1;
      default:       ok = 1'b0;
    endcase
    return ok;
  endfunction

  // keep an upper-case letter, zero anything else
  function automatic logic [7:0] upper_or_zero(input logic [7:0] c);
    return ((c >= CHAR_A) && (c <= CHAR_Z)) ? c : 8'h00;
  endfunction

endpackage

`default_nettype wire

FILE: src/scf_front.sv
// scf_front: classifies each received byte as dropped, appended or frame end
// depends on scf_pkg
`default_nettype none

module scf_front (
  input  wire logic                 push,
  input  wire logic                 full,
  input  wire logic [7:0]           rx_byte,
  output scf_pkg::queue_port_t      enq
);

  logic accepted;
  logic keep;

  // a word is taken whenever the queue has room; only useful ones go on
  assign accepted = push && !full;
  assign keep     = scf_pkg::char_allowed(rx_byte) && (rx_byte != scf_pkg::CHAR_SKIP);

  // build the queue word
  always_comb begin
    enq.valid     = accepted && keep;
    enq.word.data = rx_byte;
    enq.word.kind = (rx_byte == scf_pkg::CHAR_END) ? scf_pkg::WORD_END
                                                   : scf_pkg::WORD_APPEND;
  end

endmodule

`default_nettype wire

FILE: src/scf_queue.sv
// scf_queue: short register queue between classifier and framing back end
// depends on scf_pkg
`default_nettype none

module scf_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire scf_pkg::queue_port_t enq,
  input  wire logic                 deq,
  output logic                      full,
  output scf_pkg::queue_port_t      head
);

  localparam int DEPTH = scf_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  scf_pkg::queue_word_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_wr;
  logic do_rd;

  assign full  = (count == CNT_W'(DEPTH));
  assign do_wr = enq.valid && !full;
  assign do_rd = deq && (count != '0);

  // head of the queue
  always_comb begin
    head.valid = (count != '0);
    head.word  = slots[rd_ptr];
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(do_wr) - CNT_W'(do_rd);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= enq.word;
    end
  end

endmodule

`default_nettype wire

FILE: src/scf_back.sv
// scf_back: frame store, decode at frame end and the result register
// depends on scf_pkg
`default_nettype none

module scf_back #(
  parameter int BUF_LEN = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire scf_pkg::queue_port_t head,
  output logic                      deq,
  input  wire logic                 pop,
  output logic                      empty,
  output logic [7:0]                command_first,
  output logic [7:0]                command_second,
  output logic [39:0]               argument_chars,
  output logic [2:0]                argument_length,
  output logic [2:0]                frame_length
);

  localparam int STORE_DEPTH = BUF_LEN - 1;
  localparam int FILL_W      = $clog2(BUF_LEN);
  localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic [7:0]        store [STORE_DEPTH];
  logic [FILL_W-1:0] fill;
  logic [7:0]        view [scf_pkg::VIEW_SLOTS];
  logic              out_valid;
  logic              take_end;
  logic              take_append;
  logic [5:0]        len;
  logic [7:0]        dec_first;
  logic [7:0]        dec_second;
  logic [39:0]       dec_args;
  logic [2:0]        dec_alen;
  logic [2:0]        dec_flen;

  assign empty = !out_valid;

  // an append always goes; a frame end waits for a free result slot
  always_comb begin
    deq = 1'b0;
    if (head.valid) begin
      if (head.word.kind == scf_pkg::WORD_APPEND) begin
        deq = 1'b1;
      end else begin
        deq = !out_valid || pop;
      end
    end
  end

  assign take_append = deq && (head.word.kind == scf_pkg::WORD_APPEND);
  assign take_end    = deq && (head.word.kind == scf_pkg::WORD_END);

  // positions past the fill level read as zero
  for (genvar k = 0; k < scf_pkg::VIEW_SLOTS; k++) begin : g_view
    if (k < STORE_DEPTH) begin : g_held
      assign view[k] = (FILL_W'(k) < fill) ? store[k] : 8'h00;
    end else begin : g_none
      assign view[k] = 8'h00;
    end
  end

  // decode of the held frame
  always_comb begin
    len        = 6'(fill);
    dec_flen   = (len > 6'd7) ? 3'd7 : len[2:0];
    dec_first  = view[0];
    dec_second = 8'h00;
    dec_args   = '0;
    dec_alen   = 3'd0;
    if ((view[0] != scf_pkg::CHAR_C) && (view[0] != scf_pkg::CHAR_PLUS) &&
        (view[0] != scf_pkg::CHAR_MINUS)) begin
      dec_first  = scf_pkg::upper_or_zero(view[0]);
      dec_second = scf_pkg::upper_or_zero(view[1]);
      dec_args   = {view[6], view[5], view[4], view[3], view[2]};
      if (len > 6'd2) begin
        dec_alen = ((len - 6'd2) > 6'(scf_pkg::ARG_BYTES)) ? 3'(scf_pkg::ARG_BYTES)
                                                          : 3'(len - 6'd2);
      end
    end
  end

  // fill level and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take_end) begin
        fill <= '0;
      end else if (take_append && (fill < FILL_W'(STORE_DEPTH))) begin
        fill <= fill + 1'b1;
      end
      if (take_end) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // frame store write
  always_ff @(posedge clk) begin
    if (take_append && (fill < FILL_W'(STORE_DEPTH))) begin
      store[fill[IDX_W-1:0]] <= head.word.data;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (take_end) begin
      command_first   <= dec_first;
      command_second  <= dec_second;
      argument_chars  <= dec_args;
      argument_length <= dec_alen;
      frame_length    <= dec_flen;
    end
  end

endmodule

`default_nettype wire

FILE: src/serial_command_framer.sv
// serial_command_framer: top level, classifier, queue and framing back end
// depends on scf_pkg, scf_front, scf_queue, scf_back
//
//   channel   handshake           payload
//   input     push / full         rx_byte
//   result    empty / pop         command_first, command_second,
//                                 argument_chars, argument_length, frame_length
//
// one byte a cycle is taken while the queue has room; a byte is classified
// in the cycle it arrives and framed in the back end once it leaves the queue
// a result shows in the cycle after its '#' is dequeued if no older one waits;
// a '#' waits in the queue only while an earlier result has not been taken,
// stalling push once the two-word queue fills
// synchronous reset clears the queue, the fill level and the result valid
`default_nettype none

module serial_command_framer #(
  parameter int BUF_LEN = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  output logic              full,
  input  wire logic [7:0]   rx_byte,
  output logic              empty,
  input  wire logic         pop,
  output logic [7:0]        command_first,
  output logic [7:0]        command_second,
  output logic [39:0]       argument_chars,
  output logic [2:0]        argument_length,
  output logic [2:0]        frame_length
);

  scf_pkg::queue_port_t enq;
  scf_pkg::queue_port_t head;
  logic                 deq;

  // classifier
  scf_front u_front (
    .push    (push),
    .full    (full),
    .rx_byte (rx_byte),
    .enq     (enq)
  );

  // decoupling queue
  scf_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .enq  (enq),
    .deq  (deq),
    .full (full),
    .head (head)
  );

  // framing and decode
  scf_back #(
    .BUF_LEN (BUF_LEN)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .deq             (deq),
    .pop             (pop),
    .empty           (empty),
    .command_first   (command_first),
    .command_second  (command_second),
    .argument_chars  (argument_chars),
    .argument_length (argument_length),
    .frame_length    (frame_length)
  );

endmodule

`default_nettype wire

FILE: tb/scf_checker.sv
// scf_frame_checker: watches both handshakes of the serial command framer,
// predicts each decoded command word and compares it; depends on scf_pkg
`timescale 1ns / 100ps

module scf_frame_checker #(
  parameter int BUF_LEN = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  rx_byte,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  command_first,
  input  logic [7:0]  command_second,
  input  logic [39:0] argument_chars,
  input  logic [2:0]  argument_length,
  input  logic [2:0]  frame_length,
  output int          errors,
  output int          pending
);

  localparam int STORE_DEPTH = BUF_LEN - 1;
  localparam int ARG_LIMIT   = 5;
  localparam int FRAME_LIMIT = 7;
  localparam int CHAR_COUNT  = 36;
  localparam logic [8*CHAR_COUNT-1:0] ALLOWED_CHARS =
    ":#DCFGS+-QPYZHINTVOMBXADE0123456789d";

  typedef struct packed {
    logic [7:0]  first;
    logic [7:0]  second;
    logic [39:0] args;
    logic [2:0]  arg_len;
    logic [2:0]  frame_len;
  } command_word_t;

  logic [7:0]    frame_bytes [STORE_DEPTH];
  int            frame_fill;
  command_word_t expected_commands [$];
  int            mismatch_count;

  // membership of the accepted character set
  function automatic bit is_accepted(input logic [7:0] b);
    bit hit;
    hit = 1'b0;
    for (int k = 0; k < CHAR_COUNT; k++)
      if (ALLOWED_CHARS[8*k +: 8] == b) hit = 1'b1;
    return hit;
  endfunction

  // held byte at a position, zero where nothing was written
  function automatic logic [7:0] held_at(input int pos);
    return (pos < frame_fill && pos < STORE_DEPTH) ? frame_bytes[pos] : 8'h00;
  endfunction

  function automatic logic [7:0] letter_or_zero(input logic [7:0] c);
    return (c >= scf_pkg::CHAR_A && c <= scf_pkg::CHAR_Z) ? c : 8'h00;
  endfunction

  // take one accepted byte into the predicted frame, queue a command on '#'
  task automatic absorb_byte(input logic [7:0] b);
    command_word_t cw;
    int n;
    if (b == 8'h00 || !is_accepted(b) || b == scf_pkg::CHAR_SKIP) return;
    if (b != scf_pkg::CHAR_END) begin
      if (frame_fill < STORE_DEPTH) begin
        frame_bytes[frame_fill] = b;
        frame_fill++;
      end
      return;
    end
    cw = '0;
    cw.first = held_at(0);
    if (!(cw.first == scf_pkg::CHAR_C || cw.first == scf_pkg::CHAR_PLUS ||
          cw.first == scf_pkg::CHAR_MINUS)) begin
      cw.first = letter_or_zero(cw.first);
      cw.second = letter_or_zero(held_at(1));
      if (frame_fill > 2) begin
        n = (frame_fill - 2 > ARG_LIMIT) ? ARG_LIMIT : frame_fill - 2;
        cw.arg_len = n[2:0];
        for (int k = 0; k < n; k++) cw.args[8*k +: 8] = held_at(k + 2);
      end
    end
    n = (frame_fill > FRAME_LIMIT) ? FRAME_LIMIT : frame_fill;
    cw.frame_len = n[2:0];
    expected_commands.push_back(cw);
    frame_fill = 0;
    for (int k = 0; k < STORE_DEPTH; k++) frame_bytes[k] = 8'h00;
  endtask

  task automatic report_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // compare a taken command word with the oldest prediction
  task automatic check_command();
    command_word_t cw;
    if (expected_commands.size() == 0) begin
      report_mismatch("unexpected command word", argument_chars, 40'h0);
      return;
    end
    cw = expected_commands.pop_front();
    if (command_first !== cw.first)
      report_mismatch("command_first", command_first, cw.first);
    if (command_second !== cw.second)
      report_mismatch("command_second", command_second, cw.second);
    if (argument_chars !== cw.args)
      report_mismatch("argument_chars", argument_chars, cw.args);
    if (argument_length !== cw.arg_len)
      report_mismatch("argument_length", argument_length, cw.arg_len);
    if (frame_length !== cw.frame_len)
      report_mismatch("frame_length", frame_length, cw.frame_len);
  endtask

  // sample both handshakes at each edge
  always @(posedge clk) begin
    if (rst) begin
      frame_fill = 0;
      for (int k = 0; k < STORE_DEPTH; k++) frame_bytes[k] = 8'h00;
    end else begin
      if (push && !full) absorb_byte(rx_byte);
      if (pop && !empty) check_command();
    end
    errors  <= mismatch_count;
    pending <= expected_commands.size();
  end

endmodule

FILE: tb/serial_command_framer_tb.sv
// serial_command_framer_tb: clock, reset and byte stimulus for the framer,
// with random idling on both sides; depends on scf_pkg and scf_frame_checker
`timescale 1ns / 100ps

module serial_command_framer_tb;

  localparam int BUF_LEN     = 8;
  localparam int ITEM_TARGET = 1200;
  localparam int CALM_ITEMS  = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 20;

  localparam logic [8*20-1:0] CMD_LETTERS = "DCFGSQPYZHINTVOMBXAE";
  localparam logic [8*23-1:0] PARAM_CHARS = "0123456789ABDEFGHIXd+-C";

  localparam int DIRECTED_COUNT = 25;
  localparam logic [7:0] DIRECTED_BYTES [DIRECTED_COUNT] = '{
    scf_pkg::CHAR_END,
    scf_pkg::CHAR_C, "5", scf_pkg::CHAR_END,
    scf_pkg::CHAR_PLUS, scf_pkg::CHAR_END,
    scf_pkg::CHAR_MINUS, scf_pkg::CHAR_END,
    "G", 8'h00, 8'hFF, scf_pkg::CHAR_SKIP, "P", scf_pkg::CHAR_END,
    "d", "9", "S", "N", "1", "2", "3", "4", scf_pkg::CHAR_END,
    "H", scf_pkg::CHAR_END
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [7:0]  rx_byte = 8'h00;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic [7:0]  command_first;
  logic [7:0]  command_second;
  logic [39:0] argument_chars;
  logic [2:0]  argument_length;
  logic [2:0]  frame_length;
  int          errors;
  int          pending;

  bit calm = 1'b0;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;
  int words_sent = 0;

  always #2 clk = ~clk;

  serial_command_framer #(.BUF_LEN(BUF_LEN)) dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .rx_byte(rx_byte),
    .empty(empty), .pop(pop), .command_first(command_first),
    .command_second(command_second), .argument_chars(argument_chars),
    .argument_length(argument_length), .frame_length(frame_length)
  );

  scf_frame_checker #(.BUF_LEN(BUF_LEN)) u_checker (
    .clk(clk), .rst(rst), .push(push), .full(full), .rx_byte(rx_byte),
    .empty(empty), .pop(pop), .command_first(command_first),
    .command_second(command_second), .argument_chars(argument_chars),
    .argument_length(argument_length), .frame_length(frame_length),
    .errors(errors), .pending(pending)
  );

  // offer one word, with an occasional idle burst first, until it is taken
  task automatic send_word(input logic [7:0] b);
    if (!calm && $urandom_range(0, 9) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    push <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    words_sent++;
    if (words_sent >= ITEM_TARGET - CALM_ITEMS) calm = 1'b1;
  endtask

  // a frame byte, sometimes preceded by line noise
  task automatic send_frame_byte(input logic [7:0] b);
    int sel;
    if ($urandom_range(0, 11) == 0) begin
      sel = $urandom_range(0, 2);
      if (sel == 0) send_word(8'($urandom_range(0, 255)));
      else if (sel == 1) send_word(scf_pkg::CHAR_SKIP);
      else send_word(8'h00);
    end
    send_word(b);
  endtask

  // one random frame: mostly well formed, some empty, overlong or noisy
  task automatic send_random_frame();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      // single-character command, trailing bytes must be discarded
      n = $urandom_range(0, 2);
      if (n == 0) send_frame_byte(scf_pkg::CHAR_C);
      else if (n == 1) send_frame_byte(scf_pkg::CHAR_PLUS);
      else send_frame_byte(scf_pkg::CHAR_MINUS);
      repeat ($urandom_range(0, 2)) send_frame_byte(PARAM_CHARS[8*$urandom_range(0, 22) +: 8]);
      send_frame_byte(scf_pkg::CHAR_END);
    end else if (kind < 25) begin
      // raw noise, no terminator
      repeat ($urandom_range(1, 4)) send_word(8'($urandom_range(0, 255)));
    end else if (kind < 30) begin
      send_frame_byte(scf_pkg::CHAR_END);
    end else if (kind < 40) begin
      // overlong frame, the store fills and later bytes drop
      repeat ($urandom_range(8, 11)) send_frame_byte(PARAM_CHARS[8*$urandom_range(0, 22) +: 8]);
      send_frame_byte(scf_pkg::CHAR_END);
    end else begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1) : 2;
      repeat (n) send_frame_byte(CMD_LETTERS[8*$urandom_range(0, 19) +: 8]);
      repeat ($urandom_range(0, 5)) send_frame_byte(PARAM_CHARS[8*$urandom_range(0, 22) +: 8]);
      send_frame_byte(scf_pkg::CHAR_END);
    end
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // reset, directed words, random frames, drain and verdict
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (int k = 0; k < DIRECTED_COUNT; k++) send_word(DIRECTED_BYTES[k]);
    hold_request = 1'b1;
    while (words_sent < ITEM_TARGET) send_random_frame();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
